>>> rtl/core/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg - shared types and constants of the quicksort engine
// Command/status bundles between controller and datapath, sizes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  // register index field of paddr (word address)
  localparam logic [APB_ADDR_W-3:0] REG_SORT_DESC = '0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,    // store incoming beat
    OP_INIT,    // push the whole batch range
    OP_POP,     // read top of range stack
    OP_POPW,    // latch lo/hi, fetch pivot
    OP_PIV,     // latch pivot, fetch first element
    OP_SCAN,    // compare element against pivot
    OP_SWAP1,   // write element[place] to j
    OP_SWAP2,   // write old element[j] to place
    OP_FINRD,   // fetch element[place]
    OP_FIN1,    // write it to hi
    OP_FIN2,    // write pivot to place
    OP_PUSHL,   // push left sub-range
    OP_PUSHR,   // push right sub-range
    OP_EMITRD,  // fetch element k
    OP_EMITLD   // load output register
  } qs_op_e;

  typedef struct packed {
    qs_op_e op;
  } qs_cmd_t;

  typedef struct packed {
    logic count_ge2;
    logic scan_left;
    logic scan_same;
    logic scan_end;
    logic stack_empty;
    logic out_free;
    logic emit_last;
  } qs_status_t;

endpackage

`default_nettype wire

>>> rtl/core/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine - batch sorter for signed 32-bit values
// Top level: APB register, controller and datapath.
// ----------------------------------------------------------------------------
// Collects a batch of signed 32-bit values, one per input beat, into an
// on-chip element RAM of MAX_ITEMS entries. The beat flagged last_item_i
// kicks off an in-place quicksort (Lomuto partition, last element of each
// range as pivot) driven by an explicit range stack held in a second RAM.
// When done, the batch streams out one value per output beat, last_result_o
// on the final one. Beats beyond MAX_ITEMS are dropped and overflow_flag_o
// is raised on every result of that batch; a dropped beat flagged last
// still starts the sort. sort_descending (register 0, bit 0) picks the
// order; write it only while the block is idle.
// Loading accepts one beat per cycle while idle. Per partitioned range,
// the sort pops the range and fetches its pivot, scans each element
// against it, swaps each element that goes left, then places the pivot
// and pushes the sub-ranges; the element RAM's single read port and
// single write port (one read, one write a cycle) set this pace. Emission
// fetches each result and loads it once the output register is free. One
// batch is processed at a time; input is accepted again once the last
// result is in the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_engine #(
  parameter int unsigned MAX_ITEMS = qs_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [qs_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [qs_pkg::APB_DATA_W-1:0]       pwdata,
  output      logic [qs_pkg::APB_DATA_W-1:0]       prdata,
  output      logic                                pready,
  // input beats
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic signed [qs_pkg::DATA_W-1:0]    item_value_i,
  input  wire logic                                last_item_i,
  // result beats
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [qs_pkg::DATA_W-1:0]    sorted_value_o,
  output      logic                                last_result_o,
  output      logic                                overflow_flag_o
);
  import qs_pkg::*;

  logic       sort_desc_q;
  logic       reg_hit;
  qs_cmd_t    cmd;
  qs_status_t status;

  // register 0 sits at byte addresses 0..3
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SORT_DESC);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(sort_desc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sort_desc_q <= pwdata[0];
    end
  end

  qs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sort_desc_i     (sort_desc_q),
    .item_value_i    (item_value_i),
    .sorted_value_o  (sorted_value_o),
    .last_result_o   (last_result_o),
    .overflow_flag_o (overflow_flag_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule

`default_nettype wire

>>> rtl/core/qs_ram.sv
// ----------------------------------------------------------------------------
// qs_ram - generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/qs_ctrl.sv
// ----------------------------------------------------------------------------
// qs_ctrl - sequencer of the quicksort engine
// Walks load, partition loop, range stack handling and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               last_item_i,
  output      logic               in_ready_o,
  input  wire qs_pkg::qs_status_t status_i,
  output      qs_pkg::qs_cmd_t    cmd_o
);
  import qs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_POPW   = 4'd3;
  localparam logic [3:0] S_PIV    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_SWAP1  = 4'd6;
  localparam logic [3:0] S_SWAP2  = 4'd7;
  localparam logic [3:0] S_FINRD  = 4'd8;
  localparam logic [3:0] S_FIN1   = 4'd9;
  localparam logic [3:0] S_FIN2   = 4'd10;
  localparam logic [3:0] S_PUSHL  = 4'd11;
  localparam logic [3:0] S_PUSHR  = 4'd12;
  localparam logic [3:0] S_NEXT   = 4'd13;
  localparam logic [3:0] S_EMITRD = 4'd14;
  localparam logic [3:0] S_EMITLD = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (last_item_i) state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = status_i.count_ge2 ? S_POP : S_EMITRD;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_POPW;
      end
      S_POPW: begin
        cmd_o.op = OP_POPW;
        state_d  = S_PIV;
      end
      S_PIV: begin
        cmd_o.op = OP_PIV;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (status_i.scan_left && !status_i.scan_same) state_d = S_SWAP1;
        else if (status_i.scan_end)                     state_d = S_FINRD;
      end
      S_SWAP1: begin
        cmd_o.op = OP_SWAP1;
        state_d  = S_SWAP2;
      end
      S_SWAP2: begin
        cmd_o.op = OP_SWAP2;
        state_d  = status_i.scan_end ? S_FINRD : S_SCAN;
      end
      S_FINRD: begin
        cmd_o.op = OP_FINRD;
        state_d  = S_FIN1;
      end
      S_FIN1: begin
        cmd_o.op = OP_FIN1;
        state_d  = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.op = OP_FIN2;
        state_d  = S_PUSHL;
      end
      S_PUSHL: begin
        cmd_o.op = OP_PUSHL;
        state_d  = S_PUSHR;
      end
      S_PUSHR: begin
        cmd_o.op = OP_PUSHR;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        state_d = status_i.stack_empty ? S_EMITRD : S_POP;
      end
      S_EMITRD: begin
        cmd_o.op = OP_EMITRD;
        state_d  = S_EMITLD;
      end
      S_EMITLD: begin
        cmd_o.op = OP_EMITLD;
        if (status_i.out_free) state_d = status_i.emit_last ? S_IDLE : S_EMITRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qs_datapath.sv
// ----------------------------------------------------------------------------
// qs_datapath - storage and arithmetic of the quicksort engine
// Element RAM, range stack RAM, partition indices, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_datapath #(
  parameter int unsigned MAX_ITEMS = qs_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire qs_pkg::qs_cmd_t                   cmd_i,
  output      qs_pkg::qs_status_t                status_o,
  input  wire logic                              sort_desc_i,
  input  wire logic signed [qs_pkg::DATA_W-1:0]  item_value_i,
  output      logic signed [qs_pkg::DATA_W-1:0]  sorted_value_o,
  output      logic                              last_result_o,
  output      logic                              overflow_flag_o,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i
);
  import qs_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 2 * AW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

  // control state
  logic [CW-1:0] count_q, sp_q;
  logic          dropped_q, out_valid_q;
  logic [AW-1:0] k_q;

  // partition payload
  logic [AW-1:0]              lo_q, hi_q, j_q, place_q;
  logic signed [DATA_W-1:0]   pivot_q, a_q;

  // RAM ports
  logic                       el_we;
  logic [AW-1:0]              el_waddr, el_raddr;
  logic signed [DATA_W-1:0]   el_wdata, el_rdata;
  logic                       st_we;
  logic [AW-1:0]              st_waddr, st_raddr;
  logic [SW-1:0]              st_wdata, st_rdata;

  logic [AW-1:0] j_next, left_hi, right_lo;
  logic [CW-1:0] count_m1, sp_m1;
  logic          goes_left, push_l, push_r, out_free, emit_last, count_ge2, scan_same;

  qs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  qs_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign j_next    = j_q + AW'(1);
  assign left_hi   = place_q - AW'(1);
  assign right_lo  = place_q + AW'(1);
  assign count_m1  = count_q - CW'(1);
  assign sp_m1     = sp_q - CW'(1);
  assign goes_left = sort_desc_i ? (el_rdata >= pivot_q) : (el_rdata <= pivot_q);
  assign scan_same = (j_q == place_q);
  assign count_ge2 = (count_q >= CW'(2));
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (CW'(k_q) == count_m1);
  // only ranges of two or more elements go on the stack
  assign push_l    = (CW'(place_q) > (CW'(lo_q) + CW'(1))) && (sp_q < MaxCount);
  assign push_r    = ((CW'(place_q) + CW'(1)) < CW'(hi_q)) && (sp_q < MaxCount);

  always_comb begin
    status_o.count_ge2   = count_ge2;
    status_o.scan_left   = goes_left;
    status_o.scan_same   = scan_same;
    status_o.scan_end    = (j_next == hi_q);
    status_o.stack_empty = (sp_q == '0);
    status_o.out_free    = out_free;
    status_o.emit_last   = emit_last;
  end

  // RAM address/data steering
  always_comb begin
    el_we    = 1'b0;
    el_waddr = j_q;
    el_wdata = el_rdata;
    el_raddr = j_q;
    st_we    = 1'b0;
    st_waddr = sp_q[AW-1:0];
    st_wdata = {lo_q, hi_q};
    st_raddr = sp_m1[AW-1:0];
    unique case (cmd_i.op)
      OP_LOAD: begin
        el_we    = (count_q < MaxCount);
        el_waddr = count_q[AW-1:0];
        el_wdata = item_value_i;
      end
      OP_INIT: begin
        st_we    = count_ge2;
        st_waddr = '0;
        st_wdata = {AW'(0), count_m1[AW-1:0]};
      end
      OP_POP:   ;
      OP_POPW:  el_raddr = st_rdata[AW-1:0];
      OP_PIV:   el_raddr = lo_q;
      OP_SCAN:  el_raddr = (goes_left && !scan_same) ? place_q : j_next;
      OP_SWAP1: begin
        el_we    = 1'b1;
        el_waddr = j_q;
        el_wdata = el_rdata;
      end
      OP_SWAP2: begin
        el_we    = 1'b1;
        el_waddr = place_q;
        el_wdata = a_q;
        el_raddr = j_next;
      end
      OP_FINRD: el_raddr = place_q;
      OP_FIN1: begin
        el_we    = 1'b1;
        el_waddr = hi_q;
        el_wdata = el_rdata;
      end
      OP_FIN2: begin
        el_we    = 1'b1;
        el_waddr = place_q;
        el_wdata = pivot_q;
      end
      OP_PUSHL: begin
        st_we    = push_l;
        st_wdata = {lo_q, left_hi};
      end
      OP_PUSHR: begin
        st_we    = push_r;
        st_wdata = {right_lo, hi_q};
      end
      OP_EMITRD, OP_EMITLD: el_raddr = k_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sp_q        <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      // a new beat loaded into a free register wins over the drain
      if ((cmd_i.op == OP_EMITLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (count_q < MaxCount) count_q <= count_q + CW'(1);
          else                    dropped_q <= 1'b1;
        end
        OP_INIT: begin
          sp_q <= count_ge2 ? CW'(1) : '0;
          k_q  <= '0;
        end
        OP_POP:   sp_q <= sp_m1;
        OP_PUSHL: if (push_l) sp_q <= sp_q + CW'(1);
        OP_PUSHR: if (push_r) sp_q <= sp_q + CW'(1);
        OP_EMITLD: begin
          if (out_free) begin
            if (emit_last) begin
              count_q   <= '0;
              dropped_q <= 1'b0;
            end else begin
              k_q <= k_q + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_POPW: begin
        lo_q <= st_rdata[SW-1:AW];
        hi_q <= st_rdata[AW-1:0];
      end
      OP_PIV: begin
        pivot_q <= el_rdata;
        j_q     <= lo_q;
        place_q <= lo_q;
      end
      OP_SCAN: begin
        if (goes_left && !scan_same) begin
          a_q <= el_rdata;
        end else begin
          if (goes_left) place_q <= place_q + AW'(1);
          j_q <= j_next;
        end
      end
      OP_SWAP2: begin
        place_q <= place_q + AW'(1);
        j_q     <= j_next;
      end
      OP_EMITLD: begin
        if (out_free) begin
          sorted_value_o  <= el_rdata;
          last_result_o   <= emit_last;
          overflow_flag_o <= dropped_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> verif/quicksort_engine_tb.sv
// ----------------------------------------------------------------------------
// quicksort_engine_tb - self-checking bench for the batch sorter
// Streams batches of signed words through the input channel, predicts the
// sorted output and checks every result beat. The order register is
// reprogrammed over APB between batches.
// ----------------------------------------------------------------------------

module quicksort_engine_tb;
  import qs_pkg::*;

  localparam int unsigned ITEM_CAP       = MAX_ITEMS_DEF;
  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam int unsigned MAX_GAP        = 13;
  // the block is already idle when the last beat leaves; this is margin
  localparam int unsigned SETTLE_CYCLES  = 40;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

  localparam logic ORDER_ASCENDING  = 1'b0;
  localparam logic ORDER_DESCENDING = 1'b1;

  // register index that decodes to nothing; writes there must be ignored
  localparam logic [APB_ADDR_W-3:0] REG_SPARE = REG_SORT_DESC + 1'b1;

  // value patterns for random batches
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_DUPLICATES,
    FILL_EXTREMES,
    FILL_RUN
  } fill_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     overflow;
  } sorted_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: collects the current batch, sorts it when the last element
  // arrives and holds the resulting beats until the block sends them.
  // --------------------------------------------------------------------------
  class sort_scoreboard;
    logic signed [DATA_W-1:0] batch_q[$];
    sorted_beat_t             sorted_q[$];
    logic                     dropped;
    logic                     descending;
    int unsigned              fails;

    function new();
      dropped    = 1'b0;
      descending = ORDER_ASCENDING;
      fails      = 0;
    endfunction

    function void set_order(input logic order);
      descending = order;
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    // a may stand before b in the output
    function bit in_order(input logic signed [DATA_W-1:0] a,
                          input logic signed [DATA_W-1:0] b);
      return descending ? (a >= b) : (a <= b);
    endfunction

    function void take_element(input logic signed [DATA_W-1:0] value,
                               input logic last);
      logic signed [DATA_W-1:0] vals[$];
      logic signed [DATA_W-1:0] key;
      sorted_beat_t             beat;
      int                       i;
      int                       j;
      int                       n;
      // beats past capacity are lost but still close the batch
      if (batch_q.size() < ITEM_CAP) batch_q.push_back(value);
      else dropped = 1'b1;
      if (!last) return;
      vals = batch_q;
      n    = vals.size();
      for (i = 1; i < n; i++) begin
        key = vals[i];
        j   = i - 1;
        while (j >= 0 && !in_order(vals[j], key)) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = key;
      end
      for (i = 0; i < n; i++) begin
        beat.value    = vals[i];
        beat.last     = (i == n - 1);
        beat.overflow = dropped;
        sorted_q.push_back(beat);
      end
      batch_q.delete();
      dropped = 1'b0;
    endfunction

    function void check_beat(input logic signed [DATA_W-1:0] value,
                             input logic last, input logic overflow);
      sorted_beat_t want;
      if (sorted_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected beat: expected none, got value %0d last %0b ovf %0b",
                 $time, value, last, overflow);
        return;
      end
      want = sorted_q.pop_front();
      if (value !== want.value) begin
        fails++;
        $display("%0t: sorted_value: expected %0d, got %0d", $time, want.value, value);
      end
      if (last !== want.last) begin
        fails++;
        $display("%0t: last_result: expected %0b, got %0b", $time, want.last, last);
      end
      if (overflow !== want.overflow) begin
        fails++;
        $display("%0t: overflow_flag: expected %0b, got %0b",
                 $time, want.overflow, overflow);
      end
    endfunction

    function void check_order(input logic order);
      if (order !== descending) begin
        fails++;
        $display("%0t: sort_descending readback: expected %0b, got %0b",
                 $time, descending, order);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its wiring
  // --------------------------------------------------------------------------
  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [APB_ADDR_W-1:0]       paddr;
  logic [APB_DATA_W-1:0]       pwdata;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [DATA_W-1:0]    item_value;
  logic                        last_item;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [DATA_W-1:0]    sorted_value;
  logic                        last_result;
  logic                        overflow_flag;

  sort_scoreboard           sb;
  logic signed [DATA_W-1:0] stim_q[$];   // batch about to be sent
  int unsigned              random_items;

  quicksort_engine #(
    .MAX_ITEMS(ITEM_CAP)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .item_value_i   (item_value),
    .last_item_i    (last_item),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sorted_value_o (sorted_value),
    .last_result_o  (last_result),
    .overflow_flag_o(overflow_flag)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("quicksort_engine: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access cycle; pready is always high but
  // still waited on.
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [APB_ADDR_W-3:0] idx,
                           input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_SORT_DESC) sb.set_order(data[0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-3:0] idx,
                          output logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program the order; only bit 0 counts, so the rest is noise. Now and
  // then also hit the unused register, which must leave the order alone.
  task automatic set_sort_order(input logic order);
    logic [APB_DATA_W-1:0] data;
    logic [APB_DATA_W-1:0] readback;
    data    = $urandom;
    data[0] = order;
    apb_write(REG_SORT_DESC, data);
    if ($urandom_range(0, 2) == 0) apb_write(REG_SPARE, $urandom);
    apb_read(REG_SORT_DESC, readback);
    sb.check_order(readback[0]);
  endtask

  // --------------------------------------------------------------------------
  // Input side. Valid stays up after an accepted beat until the next falling
  // edge, where it is either reloaded (no gap) or dropped; no rising edge
  // falls in between, so the old beat is never taken twice.
  // --------------------------------------------------------------------------
  task automatic push_element(input logic signed [DATA_W-1:0] value,
                              input logic last, input bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    item_value <= value;
    last_item  <= last;
    do @(posedge clk_i); while (!in_ready);
    sb.take_element(value, last);
  endtask

  task automatic send_batch();
    bit quiet;
    int k;
    quiet = ($urandom_range(0, 3) == 0);
    for (k = 0; k < stim_q.size(); k++)
      push_element(stim_q[k], k == stim_q.size() - 1, quiet);
    stim_q.delete();
  endtask

  // Close out a phase: stop driving, let every sorted beat come back,
  // then give the block a few spare cycles before touching the register.
  task automatic drain_phase();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input fill_e fill,
                                                         input int k,
                                                         input logic [DATA_W-1:0] base,
                                                         input logic [DATA_W-1:0] step);
    case (fill)
      FILL_DUPLICATES: return $signed($urandom_range(0, 7)) - 4;
      FILL_EXTREMES: begin
        case ($urandom_range(0, 4))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return '0;
          3:       return NEG_ONE;
          default: return $urandom;
        endcase
      end
      FILL_RUN:    return base + k * step;   // sorted run, wraps freely
      default:     return $urandom;
    endcase
  endfunction

  task automatic build_batch(input int unsigned size);
    fill_e               fill;
    logic [DATA_W-1:0]   base;
    logic [DATA_W-1:0]   step;
    int                  k;
    fill = fill_e'($urandom_range(0, 3));
    base = $urandom;
    step = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 0) step = -step;   // falling run
    for (k = 0; k < size; k++) stim_q.push_back(pick_value(fill, k, base, step));
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready stalls for a random count before each beat, with
  // stretches where it never stalls. Every accepted beat is checked here.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    bit          quiet;
    int unsigned stall;
    quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_beat(sorted_value, last_result, overflow_flag);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned batch_idx;
    int unsigned n_batches;
    int unsigned size;
    int unsigned b;

    sb         = new();
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    item_value = '0;
    last_item  = 1'b0;
    out_ready  = 1'b0;
    random_items = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, ascending from reset: a lone element, a reversed pair,
    // extremes mixed with duplicates
    stim_q = '{INT_MIN};
    send_batch();
    stim_q = '{INT_MAX, INT_MIN};
    send_batch();
    stim_q = '{32'sd0, NEG_ONE, 32'sd1, INT_MAX, INT_MIN, NEG_ONE, 32'sd0};
    send_batch();
    drain_phase();

    // directed, descending: an already ascending run, all-equal, extremes
    set_sort_order(ORDER_DESCENDING);
    apb_write(REG_SPARE, '0);
    stim_q = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, INT_MAX};
    send_batch();
    stim_q = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
    send_batch();
    stim_q = '{NEG_ONE, INT_MIN, INT_MAX};
    send_batch();
    drain_phase();

    // random phases; batch 1 exactly fills the store, batch 3 overruns it
    // so the flagged-last beat is itself dropped
    phase     = 0;
    batch_idx = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) set_sort_order(ORDER_ASCENDING);
      else if (phase == 1) set_sort_order(ORDER_DESCENDING);
      else set_sort_order($urandom_range(0, 1));
      n_batches = $urandom_range(2, 4);
      for (b = 0; b < n_batches && random_items < RANDOM_ITEMS; b++) begin
        if (batch_idx == 1) size = ITEM_CAP;
        else if (batch_idx == 3) size = ITEM_CAP + $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) size = $urandom_range(17, 40);
        else size = $urandom_range(1, 12);
        build_batch(size);
        send_batch();
        random_items += size;
        batch_idx++;
      end
      drain_phase();
      phase++;
    end

    if (sb.fails == 0) begin
      $display("quicksort_engine: match");
    end else begin
      $display("quicksort_engine: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/qs_pkg.sv
rtl/core/qs_ram.sv
rtl/core/qs_ctrl.sv
rtl/core/qs_datapath.sv
rtl/core/quicksort_engine.sv
verif/quicksort_engine_tb.sv
